// ----- design/xds_pkg.sv -----
package xds_pkg;

  // xxh64 primes
  localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
  localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;

  localparam int unsigned RECORD_BYTES = 20;
  localparam logic [63:0] HASH_INIT    = XP5 + 64'(RECORD_BYTES);

  // stream widths
  localparam int unsigned ID_LO_W    = 64;
  localparam int unsigned ID_HI_W    = 32;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned OTHER_W    = 64;
  localparam int unsigned IN_DATA_W  = 224;
  localparam int unsigned RAW_W      = 64;
  localparam int unsigned FOLD_W     = 32;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - RAW_W - FOLD_W - 1;

  localparam int unsigned NUM_STEPS = 10;
  localparam int unsigned STEP_W    = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  localparam logic FUNC_TOGGLE = 1'b0;
  localparam logic FUNC_MERGE  = 1'b1;

  // one classified item between front and back
  typedef struct packed {
    logic        is_merge;
    logic [63:0] lane0;   // id bytes 0..7, or the other digest for a merge
    logic [63:0] lane1;   // id bytes 8..11 then stamp bytes 0..3
    logic [31:0] tail;    // stamp bytes 4..7
  } xds_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_WAIT,
    BK_APPLY
  } xds_bk_state_t;

  typedef enum logic [2:0] {
    OPND_LANE0,
    OPND_LANE1,
    OPND_TAIL,
    OPND_ROTK31,
    OPND_ROTH27,
    OPND_ROTH23,
    OPND_HXS33,
    OPND_HXS29
  } xds_opnd_t;

  typedef enum logic [2:0] {
    POST_K,
    POST_HXOR,
    POST_HADD4,
    POST_HADD3,
    POST_H
  } xds_post_t;

  typedef struct packed {
    xds_opnd_t   opnd;
    logic [63:0] mulc;
    xds_post_t   post;
  } xds_step_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
    logic [127:0] dbl;
    dbl = {v, v} << r;
    return dbl[127:64];
  endfunction

  // microcode for one record hash: two lane rounds, the tail word, the avalanche
  function automatic xds_step_t step_ctrl(input logic [STEP_W-1:0] step);
    xds_step_t s;
    s = '{opnd: OPND_LANE0, mulc: XP2, post: POST_K};
    case (step)
      4'd0: s = '{opnd: OPND_LANE0,  mulc: XP2, post: POST_K};
      4'd1: s = '{opnd: OPND_ROTK31, mulc: XP1, post: POST_HXOR};
      4'd2: s = '{opnd: OPND_ROTH27, mulc: XP1, post: POST_HADD4};
      4'd3: s = '{opnd: OPND_LANE1,  mulc: XP2, post: POST_K};
      4'd4: s = '{opnd: OPND_ROTK31, mulc: XP1, post: POST_HXOR};
      4'd5: s = '{opnd: OPND_ROTH27, mulc: XP1, post: POST_HADD4};
      4'd6: s = '{opnd: OPND_TAIL,   mulc: XP1, post: POST_HXOR};
      4'd7: s = '{opnd: OPND_ROTH23, mulc: XP2, post: POST_HADD3};
      4'd8: s = '{opnd: OPND_HXS33,  mulc: XP2, post: POST_H};
      4'd9: s = '{opnd: OPND_HXS29,  mulc: XP3, post: POST_H};
      default: s = '{opnd: OPND_LANE0, mulc: XP2, post: POST_K};
    endcase
    return s;
  endfunction

endpackage

// ----- design/xds_front.sv -----
module xds_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_tuser,  // func
  // id_low_bytes, id_high_bytes, stamp, other_digest
  input  logic [xds_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           q_full,
  output logic                           q_push,
  output xds_pkg::xds_item_t             q_item
);
  import xds_pkg::*;

  logic [ID_LO_W-1:0] id_lo;
  logic [ID_HI_W-1:0] id_hi;
  logic [STAMP_W-1:0] stamp;
  logic [OTHER_W-1:0] other;

  assign id_lo = in_tdata[63:0];
  assign id_hi = in_tdata[95:64];
  assign stamp = in_tdata[159:96];
  assign other = in_tdata[223:160];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // pack the 20-byte record into two 8-byte lanes and a 4-byte tail; a merge beat carries the other digest in lane0
  always_comb begin
    q_item.is_merge = (in_tuser == FUNC_MERGE);
    if (in_tuser == FUNC_MERGE) begin
      q_item.lane0 = other;
      q_item.lane1 = '0;
      q_item.tail  = '0;
    end else begin
      q_item.lane0 = id_lo;
      q_item.lane1 = {stamp[31:0], id_hi};
      q_item.tail  = stamp[63:32];
    end
  end

endmodule

// ----- design/xds_fifo.sv -----
module xds_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  xds_pkg::xds_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output xds_pkg::xds_item_t head_item
);
  import xds_pkg::*;

  xds_item_t   slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_pop    = pop && not_empty;
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- design/xds_mul.sv -----
module xds_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] mul_a,
  input  logic [63:0] mul_b,
  output logic        done,
  output logic [63:0] product
);
  import xds_pkg::*;

  // low 64 bits of a 64x64 product from three 32x32 partials
  logic [63:0] a_r, b_r;
  logic [63:0] p_r, acc_r;
  logic [1:0]  phase_r;
  logic        busy_r, done_r;
  logic [31:0] op_a, op_b;
  logic [63:0] part;

  always_comb begin
    case (phase_r)
      2'd0: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
      2'd1: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
      end
      2'd2: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    part = {32'd0, op_a} * {32'd0, op_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= mul_a;
      b_r <= mul_b;
    end else if (busy_r) begin
      p_r <= part;
      case (phase_r)
        2'd1:    acc_r <= p_r;
        2'd2:    acc_r <= acc_r + {p_r[31:0], 32'd0};
        2'd3:    acc_r <= acc_r + {p_r[31:0], 32'd0};
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ----- design/xds_back.sv -----
module xds_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_not_empty,
  input  xds_pkg::xds_item_t              q_item,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // raw_digest, folded_digest, is_empty
  output logic [xds_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import xds_pkg::*;

  xds_bk_state_t     state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  xds_item_t         item_r, item_nxt;
  logic [63:0]       h_r, h_nxt;
  logic [63:0]       k_r, k_nxt;
  logic [63:0]       digest_r, digest_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RAW_W-1:0]  out_raw_r, out_raw_nxt;
  logic [FOLD_W-1:0] out_fold_r, out_fold_nxt;
  logic              out_empty_r, out_empty_nxt;

  xds_step_t   ctl;
  logic [63:0] opnd;
  logic [63:0] hash_val;
  logic        mul_start;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic        out_free;

  xds_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mul_a   (opnd),
    .mul_b   (ctl.mulc),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign ctl      = step_ctrl(step_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    case (ctl.opnd)
      OPND_LANE0:  opnd = item_r.lane0;
      OPND_LANE1:  opnd = item_r.lane1;
      OPND_TAIL:   opnd = {32'd0, item_r.tail};
      OPND_ROTK31: opnd = rotl64(k_r, 6'd31);
      OPND_ROTH27: opnd = rotl64(h_r, 6'd27);
      OPND_ROTH23: opnd = rotl64(h_r, 6'd23);
      OPND_HXS33:  opnd = h_r ^ (h_r >> 33);
      OPND_HXS29:  opnd = h_r ^ (h_r >> 29);
      default:     opnd = '0;
    endcase
  end

  // merge beats pass the other digest straight through
  assign hash_val = item_r.is_merge ? item_r.lane0 : (h_r ^ (h_r >> 32));

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    item_nxt      = item_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    digest_nxt    = digest_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_raw_nxt   = out_raw_r;
    out_fold_nxt  = out_fold_r;
    out_empty_nxt = out_empty_r;
    q_pop         = 1'b0;
    mul_start     = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          h_nxt    = HASH_INIT;
          step_nxt = '0;
          state_nxt = q_item.is_merge ? BK_APPLY : BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        mul_start = 1'b1;
        state_nxt = BK_WAIT;
      end
      BK_WAIT: begin
        if (mul_done) begin
          case (ctl.post)
            POST_K:     k_nxt = mul_prod;
            POST_HXOR:  h_nxt = h_r ^ mul_prod;
            POST_HADD4: h_nxt = mul_prod + XP4;
            POST_HADD3: h_nxt = mul_prod + XP3;
            POST_H:     h_nxt = mul_prod;
            default:    h_nxt = h_r;
          endcase
          if (step_r == LAST_STEP) begin
            state_nxt = BK_APPLY;
          end else begin
            step_nxt  = step_r + STEP_W'(1);
            state_nxt = BK_ISSUE;
          end
        end
      end
      BK_APPLY: begin
        if (out_free) begin
          digest_nxt    = digest_r ^ hash_val;
          out_valid_nxt = 1'b1;
          out_raw_nxt   = digest_nxt;
          out_fold_nxt  = digest_nxt[63:32] ^ digest_nxt[31:0];
          out_empty_nxt = (digest_nxt == 64'd0);
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      digest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      digest_r    <= digest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    h_r         <= h_nxt;
    k_r         <= k_nxt;
    out_raw_r   <= out_raw_nxt;
    out_fold_r  <= out_fold_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_empty_r, out_fold_r, out_raw_r};

endmodule

// ----- design/xxh64_set_digest_accumulator.sv -----
// Order-independent 64-bit set digest. Each toggle beat hashes a 20-byte record
// (12-byte id, then 8-byte timestamp, little-endian) with XXH64 at seed 0 and XORs
// the hash into the digest, so adding and removing a document are the same beat;
// a merge beat (tuser = 1) XORs in another digest. Every input beat gives one output
// beat with the new digest, its 32-bit fold and an empty flag. The front side
// classifies beats into a two-entry queue; the back side hashes them one at a time
// through a single shared 32x32 multiplier, three partial products per 64-bit
// multiply and ten multiplies per record, while a merge beat skips the multiplier.
// Digest resets to zero.
module xxh64_set_digest_accumulator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_tuser,   // func
  // id_low_bytes, id_high_bytes, stamp, other_digest
  input  logic [xds_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // raw_digest, folded_digest, is_empty, zero pad
  output logic [xds_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import xds_pkg::*;

  xds_item_t push_item;
  xds_item_t head_item;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;

  xds_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  xds_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  xds_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
